// File: rtl/core/imuma_pkg.sv
package imuma_pkg;

	localparam int SAMPLE_W         = 16;
	localparam int CHANNELS         = 6;
	localparam int CH_W             = 3;
	localparam int WINDOW_DEPTH_DEF = 15;

	localparam logic [CH_W-1:0] CH_FIRST = CH_W'(0);
	localparam logic [CH_W-1:0] CH_LAST  = CH_W'(CHANNELS - 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] accel_x;
		logic signed [SAMPLE_W-1:0] accel_y;
		logic signed [SAMPLE_W-1:0] accel_z;
		logic signed [SAMPLE_W-1:0] orient_x;
		logic signed [SAMPLE_W-1:0] orient_y;
		logic signed [SAMPLE_W-1:0] orient_z;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] avg_accel_x;
		logic signed [SAMPLE_W-1:0] avg_accel_y;
		logic signed [SAMPLE_W-1:0] avg_accel_z;
		logic signed [SAMPLE_W-1:0] avg_orient_x;
		logic signed [SAMPLE_W-1:0] avg_orient_y;
		logic signed [SAMPLE_W-1:0] avg_orient_z;
	} avg_t;

endpackage

// File: rtl/core/imuma_div.sv
module imuma_div #(
	parameter int SUM_W = 20,
	parameter int CNT_W = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [SUM_W-1:0]              dividend,
	input  logic        [CNT_W-1:0]              divisor,
	output logic                                 done,
	output logic        [imuma_pkg::SAMPLE_W-1:0] quotient
);
	import imuma_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;

	logic [CNT_W:0]    rem_sh;
	logic              ge;
	logic [CNT_W:0]    rem_nx;
	logic [SUM_W-1:0]  mag;
	logic [SUM_W-1:0]  signed_quo;

	// magnitude of the dividend; the most negative sum still fits unsigned
	assign mag    = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

	// one restoring step per cycle
	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign ge     = rem_sh >= {1'b0, div_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;

	assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient   = signed_quo[SAMPLE_W-1:0];
	assign done       = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= mag;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_nx[CNT_W-1:0];
		end
	end

endmodule

// File: rtl/core/imu_six_channel_moving_average.sv
// each accepted sample beat runs through the sum update, the division and the output register to its result beat
// no new sample is taken until the last one's results reach the output register; the single
//   shared bit-serial divider works through the six channels in turn
// a waiting result sits in the output register while the next sample is accepted
// reset: sums, fill count and write slot clear at once, no clearing pass; the window
//   memory is not cleared since a slot read back only enters the sums once the window is full
module imu_six_channel_moving_average #(
	parameter int WINDOW_DEPTH = imuma_pkg::WINDOW_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  imuma_pkg::sample_t sample,
	output logic               avg_valid,
	input  logic               avg_stall,
	output imuma_pkg::avg_t    avg
);
	import imuma_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	// sample width plus growth over the window
	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a sample beat
	localparam logic [1:0] ST_UPD  = 2'd1;  // window read data back, sums updated
	localparam logic [1:0] ST_DIV  = 2'd2;  // one division per channel
	localparam logic [1:0] ST_HOLD = 2'd3;  // move results to the output register

	logic [1:0]              state_q;
	logic [CH_W-1:0]         ch_q;
	logic                    launched_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q [CHANNELS];
	logic                    avg_valid_q;

	// payload registers
	sample_t                 sample_q;
	sample_t                 rd_q;
	logic [SAMPLE_W-1:0]     res_q [CHANNELS];
	avg_t                    avg_q;

	// ring of past samples, all six channels side by side
	sample_t                 win_mem [WINDOW_DEPTH];

	logic                    accept;
	logic                    full;
	logic                    out_free;
	logic signed [SAMPLE_W-1:0] new_smp [CHANNELS];
	logic signed [SAMPLE_W-1:0] old_smp [CHANNELS];
	logic signed [SUM_W-1:0] sum_nx [CHANNELS];
	logic                    div_start;
	logic                    div_done;
	logic [SAMPLE_W-1:0]     div_quo;

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = state_q != ST_IDLE;
	assign full         = count_q == CNT_W'(WINDOW_DEPTH);
	// output register is empty or drains this cycle
	assign out_free     = !avg_valid_q || !avg_stall;

	assign avg_valid = avg_valid_q;
	assign avg       = avg_q;

	// unpack the latched sample and the evicted one into channel order
	always_comb begin
		new_smp[0] = sample_q.accel_x;
		new_smp[1] = sample_q.accel_y;
		new_smp[2] = sample_q.accel_z;
		new_smp[3] = sample_q.orient_x;
		new_smp[4] = sample_q.orient_y;
		new_smp[5] = sample_q.orient_z;
		old_smp[0] = rd_q.accel_x;
		old_smp[1] = rd_q.accel_y;
		old_smp[2] = rd_q.accel_z;
		old_smp[3] = rd_q.orient_x;
		old_smp[4] = rd_q.orient_y;
		old_smp[5] = rd_q.orient_z;
	end

	// running sums: add the new sample, drop the oldest once the window is full
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			sum_nx[c] = sum_q[c]
				+ {{(SUM_W-SAMPLE_W){new_smp[c][SAMPLE_W-1]}}, new_smp[c]}
				- (full ? {{(SUM_W-SAMPLE_W){old_smp[c][SAMPLE_W-1]}}, old_smp[c]}
				        : SUM_W'(0));
		end
	end

	assign div_start = (state_q == ST_DIV) && !launched_q;

	imuma_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[ch_q]),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= CH_FIRST;
			launched_q  <= 1'b0;
			slot_q      <= '0;
			count_q     <= '0;
			avg_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				sum_q[c] <= '0;
			end
		end else begin
			// result register: fill from the sequencer, or empty once taken
			if (state_q == ST_HOLD && out_free) begin
				avg_valid_q <= 1'b1;
			end else if (avg_valid_q && !avg_stall) begin
				avg_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					for (int c = 0; c < CHANNELS; c++) begin
						sum_q[c] <= sum_nx[c];
					end
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
					slot_q     <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
					ch_q       <= CH_FIRST;
					launched_q <= 1'b0;
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					if (!launched_q) begin
						launched_q <= 1'b1;
					end else if (div_done) begin
						launched_q <= 1'b0;
						if (ch_q == CH_LAST) begin
							state_q <= ST_HOLD;
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// window memory: read the slot about to be overwritten, write the new sample into it in the cycle after
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= win_mem[slot_q];
		end
		if (state_q == ST_UPD) begin
			win_mem[slot_q] <= sample_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
		end
		if (state_q == ST_DIV && launched_q && div_done) begin
			res_q[ch_q] <= div_quo;
		end
		if (state_q == ST_HOLD && out_free) begin
			avg_q.avg_accel_x  <= res_q[0];
			avg_q.avg_accel_y  <= res_q[1];
			avg_q.avg_accel_z  <= res_q[2];
			avg_q.avg_orient_x <= res_q[3];
			avg_q.avg_orient_y <= res_q[4];
			avg_q.avg_orient_z <= res_q[5];
		end
	end

endmodule

// File: rtl/core/imuma_checker.sv
module imuma_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_stall,
	input imuma_pkg::sample_t sample,
	input logic               avg_valid,
	input logic               avg_stall,
	input imuma_pkg::avg_t    avg
);
	import imuma_pkg::*;

	// a waiting result beat stays until taken
	a_avg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid && avg_stall |=> avg_valid)
		else $error("result beat dropped while stalled");

	// stalled result payload does not move
	a_avg_stable: assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid && avg_stall |=> $stable(avg))
		else $error("result payload changed while stalled");

	// one sample in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("sample accepted while one is in work");

	// a new result only comes out of a sample in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(avg_valid) |-> $past(sample_stall))
		else $error("result beat without a sample in work");

	// a sample beat is not followed by an early result beat
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> ##1 !$rose(avg_valid))
		else $error("result beat too early");

endmodule

bind imu_six_channel_moving_average imuma_checker u_imuma_checker (.*);

// File: sim/tb_imu_six_channel_moving_average.sv
module tb_imu_six_channel_moving_average;

	timeunit 1ns;
	timeprecision 1ps;

	import imuma_pkg::*;

	localparam int DEPTH        = WINDOW_DEPTH_DEF;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASE_BEATS  = 310;
	localparam int NUM_PHASES   = 4;

	localparam logic [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// how a random beat is made up
	typedef enum int {SHAPE_FULL, SHAPE_CORNER, SHAPE_NEAR_ZERO, SHAPE_REPEAT} shape_t;

	// one row of the directed stimulus; pinned rows carry a hand-typed mean
	typedef struct {
		sample_t beat;
		logic    pinned;
		avg_t    pinned_mean;
	} stim_row_t;

	// idling per phase, in percent: none, sender, receiver, both
	int send_idle_by_phase [NUM_PHASES] = '{0, 85, 0, 34};
	int recv_stall_by_phase[NUM_PHASES] = '{0, 0, 85, 34};

	// channel index c covers bits [c*SAMPLE_W +: SAMPLE_W], lowest field first
	string field_name [CHANNELS] = '{"avg_orient_z", "avg_orient_y", "avg_orient_x",
		"avg_accel_z", "avg_accel_y", "avg_accel_x"};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_stall;
	sample_t sample;
	logic    avg_valid;
	logic    avg_stall = 1'b0;
	avg_t    avg;

	// travels with the sample beat so the accept side knows what to expect
	logic    pinned;
	avg_t    pinned_mean;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int cycle_count    = 0;
	int beats_sent     = 0;
	int results_seen   = 0;

	avg_t      expected_means[$];
	stim_row_t stim_rows[$];
	sample_t   last_random = '0;

	// own copy of the sliding window
	logic signed [SAMPLE_W-1:0] ring [DEPTH][CHANNELS];
	int chan_sum [CHANNELS];
	int fill_count = 0;
	int write_slot = 0;

	always #4 clk = ~clk;

	imu_six_channel_moving_average #(
		.WINDOW_DEPTH(DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.avg_valid    (avg_valid),
		.avg_stall    (avg_stall),
		.avg          (avg)
	);

	// push one sample into the window and work out the six means
	function automatic avg_t slide_window(sample_t s);
		avg_t m;
		logic signed [SAMPLE_W-1:0] x;
		for (int c = 0; c < CHANNELS; c++) begin
			x = s[c*SAMPLE_W +: SAMPLE_W];
			// once full, the oldest sample in this slot leaves the sum
			if (fill_count == DEPTH)
				chan_sum[c] -= ring[write_slot][c];
			ring[write_slot][c] = x;
			chan_sum[c] += x;
		end
		if (fill_count < DEPTH)
			fill_count++;
		write_slot = (write_slot + 1 == DEPTH) ? 0 : write_slot + 1;
		// int division truncates toward zero, as the block must
		for (int c = 0; c < CHANNELS; c++)
			m[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(chan_sum[c] / fill_count);
		return m;
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		shape_t shape;
		int unsigned r;
		r = $urandom_range(19);
		shape = (r < 11) ? SHAPE_FULL : (r < 15) ? SHAPE_CORNER :
			(r < 18) ? SHAPE_NEAR_ZERO : SHAPE_REPEAT;
		if (shape == SHAPE_REPEAT)
			return last_random;
		for (int c = 0; c < CHANNELS; c++) begin
			case (shape)
				SHAPE_CORNER: begin
					case ($urandom_range(4))
						0: s[c*SAMPLE_W +: SAMPLE_W] = S_MAX;
						1: s[c*SAMPLE_W +: SAMPLE_W] = S_MIN;
						2: s[c*SAMPLE_W +: SAMPLE_W] = '0;
						3: s[c*SAMPLE_W +: SAMPLE_W] = '1;
						default: s[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(1);
					endcase
				end
				// small values of both signs show up truncation toward zero
				SHAPE_NEAR_ZERO: s[c*SAMPLE_W +: SAMPLE_W] =
					SAMPLE_W'($urandom_range(14)) - SAMPLE_W'(7);
				default: s[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom);
			endcase
		end
		last_random = s;
		return s;
	endfunction

	task automatic flag_mismatch(string what);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	task automatic add_row(sample_t s, logic pin, avg_t pin_mean);
		stim_row_t row;
		row.beat        = s;
		row.pinned      = pin;
		row.pinned_mean = pin_mean;
		stim_rows = {stim_rows, row};
	endtask

	// offer one sample beat, with random idle cycles ahead of it
	task automatic send_beat(sample_t s, logic pin, avg_t pin_mean);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		pinned       <= pin;
		pinned_mean  <= pin_mean;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	// sender holds off until every sent beat has its result back
	task automatic hold_until_drained();
		while (results_seen < beats_sent) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// receiver stalls at random at the rate of the current phase
	always @(posedge clk) begin
		avg_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// every accepted sample beat moves the window on and queues its means
	always @(posedge clk) begin : predict_on_accept
		avg_t m;
		if (arst_n && sample_valid && !sample_stall) begin
			m = slide_window(sample);
			if (pinned)
				m = pinned_mean;
			expected_means = {expected_means, m};
		end
	end

	// every accepted result beat is checked field by field against the oldest mean
	always @(posedge clk) begin : check_results
		avg_t want;
		if (arst_n && avg_valid && !avg_stall) begin
			results_seen++;
			if (expected_means.size() == 0) begin
				flag_mismatch("result beat with no mean waiting");
			end else begin
				want = expected_means[0];
				expected_means.delete(0);
				for (int c = 0; c < CHANNELS; c++) begin
					if (avg[c*SAMPLE_W +: SAMPLE_W] !== want[c*SAMPLE_W +: SAMPLE_W])
						flag_mismatch($sformatf("%s got %0d want %0d", field_name[c],
							$signed(avg[c*SAMPLE_W +: SAMPLE_W]),
							$signed(want[c*SAMPLE_W +: SAMPLE_W])));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("imu_six_channel_moving_average test failed");
			$finish;
		end
	end

	initial begin : stimulus
		sample_t mixed;
		sample_t mixed_flip;
		sample_t all_min;
		sample_t all_max;
		sample_valid <= 1'b0;
		sample       <= '0;
		pinned       <= 1'b0;
		pinned_mean  <= '0;
		arst_n       <= 1'b0;

		// extremes and the signs around zero in one beat
		mixed      = {S_MAX, S_MIN, SAMPLE_W'(0), SAMPLE_W'(-1), SAMPLE_W'(1),
			SAMPLE_W'(16384)};
		mixed_flip = {S_MIN, S_MAX, SAMPLE_W'(-1), SAMPLE_W'(0), SAMPLE_W'(-1),
			SAMPLE_W'(-16384)};
		all_min    = {CHANNELS{S_MIN}};
		all_max    = {CHANNELS{S_MAX}};

		// first beat after reset: the mean is the beat itself
		add_row(mixed, 1'b1, avg_t'(mixed));
		// same beat again, mean unchanged
		add_row(mixed, 1'b1, avg_t'(mixed));
		// negative sums that do not divide evenly, truncation toward zero
		add_row(mixed_flip, 1'b0, '0);
		// fill the whole window with the most negative value
		for (int i = 0; i < DEPTH; i++)
			add_row(all_min, (i == DEPTH - 1), avg_t'(all_min));
		// full window: the most negative samples get evicted by the most positive
		for (int i = 0; i < 5; i++)
			add_row(all_max, 1'b0, '0);
		add_row('0, 1'b0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_beat(stim_rows[i].beat, stim_rows[i].pinned, stim_rows[i].pinned_mean);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// pipeline empties before the idling pattern changes
			hold_until_drained();
			send_idle_pct  = send_idle_by_phase[ph];
			recv_stall_pct = recv_stall_by_phase[ph];
			for (int i = 0; i < PHASE_BEATS; i++)
				send_beat(random_sample(), 1'b0, '0);
		end

		hold_until_drained();
		recv_stall_pct = 0;
		// anything stray from the block turns up in this window
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("imu_six_channel_moving_average test passed");
		end else begin
			$display("imu_six_channel_moving_average test failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/imuma_pkg.sv
rtl/core/imuma_div.sv
rtl/core/imu_six_channel_moving_average.sv
rtl/core/imuma_checker.sv
sim/tb_imu_six_channel_moving_average.sv
